@@ design/dq_pkg.sv @@
// Shared types and codes for the double-ended queue.
`default_nettype none
package dq_pkg;

  // Action codes as carried on the input item
  typedef enum logic [2:0] {
    OP_PUSH_F = 3'd0,
    OP_PUSH_B = 3'd1,
    OP_POP_F  = 3'd2,
    OP_POP_B  = 3'd3,
    OP_LIST_F = 3'd4,
    OP_LIST_B = 3'd5
  } op_t;

  localparam logic [2:0] ACT_MAX = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int CQ_DEPTH = 2;
  localparam int RQ_DEPTH = 4;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [31:0] item_value;
    logic [1:0]  status;
    logic        last;
  } res_t;

  typedef enum logic {
    BK_IDLE,
    BK_LIST
  } bk_state_t;

endpackage
`default_nettype wire

@@ design/dq_front.sv @@
// Front end: accepts input items, decodes the action and queues commands.
`default_nettype none
module dq_front import dq_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_push,
  output logic               in_full,
  input  wire [2:0]          in_action,
  input  wire signed [31:0]  in_value,
  output logic               cq_vld,
  output cmd_t               cq_cmd,
  input  wire                cq_take
);

  localparam int PW = $clog2(CQ_DEPTH);
  localparam int NW = $clog2(CQ_DEPTH + 1);

  cmd_t          cq_mem_r [CQ_DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          enq, deq;

  assign in_full = (cnt_r == NW'(CQ_DEPTH));
  assign cq_vld  = (cnt_r != '0);
  assign cq_cmd  = cq_mem_r[rptr_r];

  // Drop undefined actions at the door: they cause nothing
  assign enq = in_push && !in_full && (in_action <= ACT_MAX);
  assign deq = cq_take && cq_vld;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (enq) begin
      wptr_nxt = (wptr_r == PW'(CQ_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (deq) begin
      rptr_nxt = (rptr_r == PW'(CQ_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    priority if (enq && !deq) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (deq && !enq) begin
      cnt_nxt = cnt_r - NW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      cq_mem_r[wptr_r] <= '{op: op_t'(in_action), value: in_value};
    end
  end

endmodule
`default_nettype wire

@@ design/dq_back.sv @@
// Back end: ring store, front pointer and occupancy; executes commands.
`default_nettype none
module dq_back import dq_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cq_vld,
  input  cmd_t       cq_cmd,
  output logic       cq_take,
  input  wire [2:0]  rq_cnt,
  output logic       res_vld,
  output res_t       res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata_r;

  bk_state_t     state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic          dir_r, dir_nxt;
  logic          rs_vld_r, rs_vld_nxt;
  logic          rs_rd_r, rs_rd_nxt;
  logic [1:0]    rs_status_r, rs_status_nxt;
  logic          rs_last_r, rs_last_nxt;

  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [31:0]   wd;
  logic          can_issue, is_full, is_empty;
  logic [SW-1:0] sum_fo;
  logic [AW-1:0] tail_pos, back_pos;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
    return t[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  // Hold back while the result queue could not absorb what is in flight
  assign can_issue = (rq_cnt + {2'b00, rs_vld_r}) < 3'(RQ_DEPTH);
  assign is_full   = (occ_r == CW'(DEPTH));
  assign is_empty  = (occ_r == '0);
  assign sum_fo    = SW'(front_r) + SW'(occ_r);
  assign tail_pos  = wrap(sum_fo);
  assign back_pos  = wrap(sum_fo - SW'(1));

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    occ_nxt       = occ_r;
    pos_nxt       = pos_r;
    left_nxt      = left_r;
    dir_nxt       = dir_r;
    rs_vld_nxt    = 1'b0;
    rs_rd_nxt     = 1'b0;
    rs_status_nxt = ST_OK;
    rs_last_nxt   = 1'b1;
    we            = 1'b0;
    re            = 1'b0;
    wa            = tail_pos;
    ra            = front_r;
    wd            = cq_cmd.value;
    cq_take       = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (cq_vld && can_issue) begin
          cq_take    = 1'b1;
          rs_vld_nxt = 1'b1;
          unique case (cq_cmd.op)
            OP_PUSH_F, OP_PUSH_B: begin
              if (is_full) begin
                rs_status_nxt = ST_FULL;
              end else begin
                we      = 1'b1;
                occ_nxt = occ_r + CW'(1);
                if (cq_cmd.op == OP_PUSH_F) begin
                  wa        = dec(front_r);
                  front_nxt = dec(front_r);
                end
              end
            end
            OP_POP_F, OP_POP_B: begin
              if (is_empty) begin
                rs_status_nxt = ST_EMPTY;
              end else begin
                re        = 1'b1;
                rs_rd_nxt = 1'b1;
                occ_nxt   = occ_r - CW'(1);
                if (cq_cmd.op == OP_POP_F) begin
                  front_nxt = inc(front_r);
                end else begin
                  ra = back_pos;
                end
              end
            end
            OP_LIST_F, OP_LIST_B: begin
              if (is_empty) begin
                rs_status_nxt = ST_EMPTY;
              end else begin
                re          = 1'b1;
                rs_rd_nxt   = 1'b1;
                rs_last_nxt = (occ_r == CW'(1));
                dir_nxt     = (cq_cmd.op == OP_LIST_B);
                ra          = (cq_cmd.op == OP_LIST_B) ? back_pos : front_r;
                pos_nxt     = (cq_cmd.op == OP_LIST_B) ? dec(back_pos) : inc(front_r);
                left_nxt    = occ_r - CW'(1);
                if (occ_r != CW'(1)) begin
                  state_nxt = BK_LIST;
                end
              end
            end
            default: begin
              rs_vld_nxt = 1'b0;
            end
          endcase
        end
      end
      BK_LIST: begin
        // Walk the ring one entry per cycle while the result queue has room
        if (can_issue) begin
          re          = 1'b1;
          ra          = pos_r;
          rs_vld_nxt  = 1'b1;
          rs_rd_nxt   = 1'b1;
          rs_last_nxt = (left_r == CW'(1));
          pos_nxt     = dir_r ? dec(pos_r) : inc(pos_r);
          left_nxt    = left_r - CW'(1);
          if (left_r == CW'(1)) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      front_r  <= '0;
      occ_r    <= '0;
      pos_r    <= '0;
      left_r   <= '0;
      dir_r    <= 1'b0;
      rs_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      occ_r    <= occ_nxt;
      pos_r    <= pos_nxt;
      left_r   <= left_nxt;
      dir_r    <= dir_nxt;
      rs_vld_r <= rs_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rs_rd_r     <= rs_rd_nxt;
    rs_status_r <= rs_status_nxt;
    rs_last_r   <= rs_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

  assign res_vld        = rs_vld_r;
  assign res.item_value = rs_rd_r ? rdata_r : 32'd0;
  assign res.status     = rs_status_r;
  assign res.last       = rs_last_r;

endmodule
`default_nettype wire

@@ design/dq_resq.sv @@
// Result queue: buffers finished results for the output side.
`default_nettype none
module dq_resq import dq_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                res_vld,
  input  res_t               res,
  output logic [2:0]         rq_cnt,
  output logic               out_empty,
  input  wire                out_pop,
  output logic signed [31:0] out_item_value,
  output logic [1:0]         out_status,
  output logic               out_last
);

  localparam int PW = $clog2(RQ_DEPTH);

  res_t          rq_mem_r [RQ_DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          deq;
  res_t          head;

  assign out_empty      = (cnt_r == '0);
  assign deq            = out_pop && !out_empty;
  assign head           = rq_mem_r[rptr_r];
  assign out_item_value = $signed(head.item_value);
  assign out_status     = head.status;
  assign out_last       = head.last;
  assign rq_cnt         = cnt_r;

  always_comb begin
    wptr_nxt = res_vld ? wptr_r + PW'(1) : wptr_r;
    rptr_nxt = deq ? rptr_r + PW'(1) : rptr_r;
    priority if (res_vld && !deq) begin
      cnt_nxt = cnt_r + 3'd1;
    end else if (deq && !res_vld) begin
      cnt_nxt = cnt_r - 3'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      rq_mem_r[wptr_r] <= res;
    end
  end

endmodule
`default_nettype wire

@@ design/double_ended_queue.sv @@
// Double-ended queue of signed 32-bit values: top level.
// A push or pop result goes through the command queue, back-end registers and result queue.
// Throughput: one push or pop per cycle while the result queue has room; a listing of n values
// emits n results, one per cycle while there is room, as the single ring read port walks the entries.
// Reset clears the front pointer, occupancy and both command and result queues;
// store contents stay undefined until written, and no clearing pass runs.
`default_nettype none
module double_ended_queue import dq_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_push,
  output logic               in_full,
  input  wire [2:0]          in_action,
  input  wire signed [31:0]  in_value,
  output logic               out_empty,
  input  wire                out_pop,
  output logic signed [31:0] out_item_value,
  output logic [1:0]         out_status,
  output logic               out_last
);

  logic       cq_vld, cq_take, res_vld;
  cmd_t       cq_cmd;
  res_t       res;
  logic [2:0] rq_cnt;

  dq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_action (in_action),
    .in_value  (in_value),
    .cq_vld    (cq_vld),
    .cq_cmd    (cq_cmd),
    .cq_take   (cq_take)
  );

  dq_back #(.DEPTH(DEPTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cq_vld  (cq_vld),
    .cq_cmd  (cq_cmd),
    .cq_take (cq_take),
    .rq_cnt  (rq_cnt),
    .res_vld (res_vld),
    .res     (res)
  );

  dq_resq u_resq (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_vld        (res_vld),
    .res            (res),
    .rq_cnt         (rq_cnt),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_item_value (out_item_value),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rq_cnt <= 3'(RQ_DEPTH))
    else $error("result queue overflow");

  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cq_take |-> cq_vld)
    else $error("command taken from an empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && rq_cnt == 3'(RQ_DEPTH)) |-> (out_pop && !out_empty))
    else $error("result written into a full queue");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("results visible after reset");

endmodule
`default_nettype wire
